### rtl/hsd_pkg.sv
// shared types and constants for the descending heap sort unit
`timescale 1ns / 1ps

package hsd_pkg;

  localparam int unsigned ValueW = 32;

  // one slot of the sorting chain: a value and whether it is occupied
  typedef struct packed {
    logic                     vld;
    logic signed [ValueW-1:0] val;
  } hsd_entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } hsd_state_e;

endpackage

### rtl/hsd_in_if.sv
// input channel: one value per transfer with an end-of-set mark
`timescale 1ns / 1ps

interface hsd_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [hsd_pkg::ValueW-1:0] value;
  logic                              end_of_set;

  modport source (output valid, output value, output end_of_set, input ready);
  modport sink (input valid, input value, input end_of_set, output ready);
endinterface

### rtl/hsd_out_if.sv
// output channel: sorted values, largest first
`timescale 1ns / 1ps

interface hsd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hsd_pkg::ValueW-1:0] sorted_value;
  logic                              last_result;
  logic                              overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink (input valid, input sorted_value, input last_result,
                input overflow, output ready);
endinterface

### rtl/heap_sort_descending_unit.sv
// top level: systolic insertion chain that returns each set largest first
`timescale 1ns / 1ps
// loading: one input transfer per cycle, up to CAPACITY values held per set
// after the end-marked transfer the chain settles while the last value walks
// down the row of cells; then one result per cycle while the sink is ready;
// the next set is taken after the final result
// reset empties the chain and clears the count and the overflow flag

module heap_sort_descending_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsd_in_if.sink     in_i,
  hsd_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  hsd_pkg::hsd_state_e state_d, state_q;
  logic [CntW-1:0]     held_d, held_q;
  logic [CntW-1:0]     settle_d, settle_q;
  logic                drop_d, drop_q;

  logic in_xfer, out_xfer, full, shift;

  hsd_pkg::hsd_entry_t head;
  hsd_pkg::hsd_entry_t stored [CAPACITY];
  hsd_pkg::hsd_entry_t link [CAPACITY-1];

  assign full     = (held_q == CntW'(CAPACITY));
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign shift    = out_xfer;

  assign head.vld = in_xfer && !full;
  assign head.val = in_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    hsd_pkg::hsd_entry_t ins, nxt;
    if (i == 0) begin : g_first
      assign ins = head;
    end else begin : g_mid
      assign ins = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign nxt = '0;
      hsd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .ins_i   (ins),
        .next_i  (nxt),
        .store_o (stored[i]),
        .pass_o  ()
      );
    end else begin : g_body
      assign nxt = stored[i+1];
      hsd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .ins_i   (ins),
        .next_i  (nxt),
        .store_o (stored[i]),
        .pass_o  (link[i])
      );
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hsd_pkg::ST_LOAD: begin
        if (in_xfer && in_i.end_of_set) state_d = hsd_pkg::ST_SETTLE;
      end
      hsd_pkg::ST_SETTLE: begin
        if (settle_q == '0) state_d = hsd_pkg::ST_DRAIN;
      end
      hsd_pkg::ST_DRAIN: begin
        if (out_xfer && held_q == CntW'(1)) state_d = hsd_pkg::ST_LOAD;
      end
      default: state_d = hsd_pkg::ST_LOAD;
    endcase
  end

  // counters and flags
  always_comb begin
    held_d   = held_q;
    settle_d = settle_q;
    drop_d   = drop_q;
    case (state_q)
      hsd_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (full) drop_d = 1'b1;
          else      held_d = held_q + CntW'(1);
          settle_d = CntW'(CAPACITY);
        end
      end
      hsd_pkg::ST_SETTLE: begin
        settle_d = settle_q - CntW'(1);
      end
      hsd_pkg::ST_DRAIN: begin
        // held count doubles as the remaining-results counter
        if (out_xfer) begin
          held_d = held_q - CntW'(1);
          if (held_q == CntW'(1)) drop_d = 1'b0;
        end
      end
      default: begin
        held_d = '0;
        drop_d = 1'b0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready         = (state_q == hsd_pkg::ST_LOAD);
    out_o.valid        = (state_q == hsd_pkg::ST_DRAIN);
    out_o.sorted_value = stored[0].val;
    out_o.last_result  = (held_q == CntW'(1));
    out_o.overflow     = drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hsd_pkg::ST_LOAD;
      held_q   <= '0;
      settle_q <= '0;
      drop_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      settle_q <= settle_d;
      drop_q   <= drop_d;
    end
  end

endmodule

### rtl/hsd_cell.sv
// one cell of the sorting chain: keeps the larger value, passes the smaller on
`timescale 1ns / 1ps

module hsd_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  hsd_pkg::hsd_entry_t ins_i,
  input  hsd_pkg::hsd_entry_t next_i,
  output hsd_pkg::hsd_entry_t store_o,
  output hsd_pkg::hsd_entry_t pass_o
);

  hsd_pkg::hsd_entry_t store_d, store_q;
  hsd_pkg::hsd_entry_t pass_d, pass_q;

  always_comb begin
    store_d    = store_q;
    pass_d.vld = 1'b0;
    pass_d.val = ins_i.val;
    if (shift_i) begin
      // drain: move one place toward the head
      store_d = next_i;
    end else if (ins_i.vld) begin
      if (!store_q.vld) begin
        store_d = ins_i;
      end else if ($signed(ins_i.val) > $signed(store_q.val)) begin
        store_d = ins_i;
        pass_d  = store_q;
      end else begin
        pass_d = ins_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      pass_q  <= '0;
    end else begin
      store_q <= store_d;
      pass_q  <= pass_d;
    end
  end

  assign store_o = store_q;
  assign pass_o  = pass_q;

endmodule
